### rtl/bresenham_line_pixels_core_assert.svh
// Assertion macros shared by the line pixel generator RTL.
// Sampled on clock, disabled while reset is high; no other dependencies.
`ifndef BRESENHAM_LINE_PIXELS_CORE_ASSERT_SVH
`define BRESENHAM_LINE_PIXELS_CORE_ASSERT_SVH

// Check an implication property on every clock edge outside reset.
`define BLP_ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a plain condition on every clock edge outside reset.
`define BLP_ASSERT_TRUE(label, expr, msg) \
   `BLP_ASSERT_PROP(label, (1'b1 |-> (expr)), msg)

`endif

### rtl/blp_pkg.sv
// Shared types and constants for the line pixel generator.
// Used by the front, the job queue, the stepper and the top level.
package blp_pkg;

   localparam int COORD_BITS  = 6;
   localparam int ERR_BITS    = COORD_BITS + 2;
   // queue depth must be a power of two so the pointers wrap by themselves
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last_pixel;
   } rsp_type;

   // one classified line: current point, directions, remaining steps and error terms
   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      x_neg;
      logic      y_neg;
      logic      x_major;
      coord_type major;
      err_type   straight;
      err_type   diag;
      err_type   err;
   } job_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   // +1 or -1 in coordinate width
   function automatic coord_type unit_step(input logic neg);
      coord_type s;
      s = neg ? {COORD_BITS{1'b1}} : COORD_BITS'(1);
      return s;
   endfunction

endpackage

### rtl/bresenham_line_pixels_core.sv
// Line pixel generator top level: request front end, job queue, pixel stepper.
// Depends on blp_pkg, blp_front, blp_queue and blp_stepper.
//
// Usage:
//   req_* carries one line (start_x, start_y, end_x, end_y); a transaction
//   completes on a clock edge with req_valid high and req_stall low.
//   rsp_* returns the pixels of each line in order, start point first; the
//   end point has last_pixel set. A line gives max(|dx|,|dy|)+1 pixels,
//   up to 64 at six coordinate bits.
//   A taken request is written into the queue, then loaded into the stepper
//   output register once the stepper is free, which puts its first pixel on
//   rsp_valid and rsp_data. The stepper emits one pixel per cycle while
//   rsp_stall is low; the next queued line follows the end point with no gap.
//   A two-entry queue takes requests while the stepper works, so req_stall
//   rises only once two lines wait behind the one being drawn.
//   When rsp_stall is high the current pixel holds and stepping pauses.
//   Reset (synchronous, active high) empties the queue and drops rsp_valid.
module bresenham_line_pixels_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  blp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output blp_pkg::rsp_type rsp_data
);
   import blp_pkg::*;

   queue_status_type q_status;
   job_type          push_job;
   job_type          head_job;
   logic             push;
   logic             pop;

   blp_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .job       (push_job)
   );

   blp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   blp_stepper u_stepper (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/blp_front.sv
// Front end: takes line requests and classifies them into stepping jobs.
// Depends on blp_pkg; pushes into blp_queue.
module blp_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  blp_pkg::req_type          req_data,
   input  blp_pkg::queue_status_type q_status,
   output logic                      push,
   output blp_pkg::job_type          job
);
   import blp_pkg::*;

   coord_type dx;
   coord_type dy;
   coord_type major;
   coord_type minor;
   logic      x_neg;
   logic      y_neg;
   logic      x_major;
   err_type   major_s;
   err_type   minor_s;

   assign req_stall = q_status.full;
   assign push      = req_valid & ~q_status.full;

   always_comb begin
      x_neg   = !(req_data.start_x < req_data.end_x);
      y_neg   = !(req_data.start_y < req_data.end_y);
      dx      = x_neg ? (req_data.start_x - req_data.end_x)
                      : (req_data.end_x - req_data.start_x);
      dy      = y_neg ? (req_data.start_y - req_data.end_y)
                      : (req_data.end_y - req_data.start_y);
      // equal spans take y as the major axis
      x_major = dx > dy;
      major   = x_major ? dx : dy;
      minor   = x_major ? dy : dx;
      major_s = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, major});
      minor_s = $signed({{(ERR_BITS-COORD_BITS){1'b0}}, minor});

      job.x        = req_data.start_x;
      job.y        = req_data.start_y;
      job.x_neg    = x_neg;
      job.y_neg    = y_neg;
      job.x_major  = x_major;
      job.major    = major;
      job.straight = minor_s <<< 1;
      job.diag     = (minor_s - major_s) <<< 1;
      job.err      = (minor_s <<< 1) - major_s;
   end

endmodule

### rtl/blp_queue.sv
// Short job queue between the request front end and the pixel stepper.
// Depends on blp_pkg for the job type and depth constants.
module blp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  blp_pkg::job_type          push_job,
   input  logic                      pop,
   output blp_pkg::job_type          head_job,
   output blp_pkg::queue_status_type status
);
   import blp_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   assign head_job         = entry_ff[rd_ptr_ff];
   assign status.not_empty = count_ff != '0;
   assign status.full      = count_ff == QCNT_BITS'(QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/blp_stepper.sv
// Back end: walks one line job pixel by pixel into the response register.
// Depends on blp_pkg and the assertion macros header.
`include "bresenham_line_pixels_core_assert.svh"

module blp_stepper (
   input  logic                      clock,
   input  logic                      reset,
   input  blp_pkg::queue_status_type q_status,
   input  blp_pkg::job_type          head_job,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output blp_pkg::rsp_type          rsp_data
);
   import blp_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    last;
   logic    advance;

   assign last    = job_ff.major == '0;
   assign advance = valid_ff & ~rsp_stall;
   // take the next job when the output register is empty or its end point leaves
   assign pop     = q_status.not_empty & (~valid_ff | (advance & last));

   assign rsp_valid           = valid_ff;
   assign rsp_data.pixel_x    = job_ff.x;
   assign rsp_data.pixel_y    = job_ff.y;
   assign rsp_data.last_pixel = last;

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      if (pop) begin
         valid_in = 1'b1;
         job_in   = head_job;
      end else if (advance && last) begin
         valid_in = 1'b0;
      end else if (advance) begin
         job_in.major = job_ff.major - COORD_BITS'(1);
         if (!job_ff.err[ERR_BITS-1]) begin
            job_in.x   = job_ff.x + unit_step(job_ff.x_neg);
            job_in.y   = job_ff.y + unit_step(job_ff.y_neg);
            job_in.err = job_ff.err + job_ff.diag;
         end else begin
            job_in.err = job_ff.err + job_ff.straight;
            if (job_ff.x_major) begin
               job_in.x = job_ff.x + unit_step(job_ff.x_neg);
            end else begin
               job_in.y = job_ff.y + unit_step(job_ff.y_neg);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   `BLP_ASSERT_PROP(a_step_keeps_line, (advance && !last) |=> (valid_ff && job_ff.major == $past(job_ff.major) - COORD_BITS'(1)), "pixel step lost the line or miscounted")
   `BLP_ASSERT_PROP(a_pop_only_when_free, pop |-> (!valid_ff || (advance && last)), "job loaded over a pixel still pending")
   `BLP_ASSERT_PROP(a_stall_holds_pixel, (valid_ff && rsp_stall) |=> (valid_ff && $stable(job_ff.x) && $stable(job_ff.y) && $stable(job_ff.major)), "stalled pixel changed")

endmodule
